### rtl/rgbct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbct_pkg: shared types and constants of the color temperature block
// Holds the RGB-to-XYZ matrix, the McCamy polynomial constants and the tag
// that travels with each reading down the pipeline.
// ----------------------------------------------------------------------------
package rgbct_pkg;

	// Width of one raw sensor channel and of each result field.
	localparam int RAW_W = 16;

	// Polynomial fraction bits and the width of the Horner accumulator.
	localparam int POLY_FRAC_BITS = 16;
	localparam int TW = 38;

	// Matrix coefficients in units of 1e-5; rows X, Y, Z; columns r, g, b.
	localparam int MAT_E5 [9] = '{
		-14282, 154924, -95641,
		-32466, 157837, -73191,
		-68202,  77073,  56332
	};

	// McCamy coefficients at POLY_FRAC_BITS, rounded to nearest.
	localparam logic signed [TW-1:0] K449  = TW'(64'sd449 <<< POLY_FRAC_BITS);
	localparam logic signed [TW-1:0] K3525 = TW'(64'sd3525 <<< POLY_FRAC_BITS);
	localparam logic signed [TW-1:0] K6823 =
		TW'((64'sd68233 * (64'sd1 <<< POLY_FRAC_BITS) + 64'sd5) / 64'sd10);
	localparam logic signed [TW-1:0] K5520 =
		TW'((64'sd552033 * (64'sd1 <<< POLY_FRAC_BITS) + 64'sd50) / 64'sd100);

	// Per-reading status that follows the data through the pipeline.
	typedef struct packed {
		logic             inv;
		logic [RAW_W-1:0] lux;
	} tag_t;

endpackage
`default_nettype wire

### rtl/rgb_color_temperature_and_lux.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_color_temperature_and_lux: correlated color temperature and lux
// Maps one raw RGB reading to XYZ, forms chromaticity and evaluates McCamy's
// cubic. Fully pipelined, one reading per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) takes one red, green, blue reading
//   per transaction; the output channel (out_valid/out_ready) returns one
//   color_temp, illuminance, temp_invalid transaction for each reading, in
//   order. A new reading is taken every cycle while results are drained.
//   Most of the pipeline depth comes from the two bit-per-stage dividers:
//   the chromaticity divide by X+Y+Z and the divide that forms n.
//   Throughput is one transaction per cycle while the output is not stalled.
//   Reset clears all valid bits; the pipeline is empty afterwards.
//   When the receiver stalls with a result pending, the whole pipeline
//   holds, and in_ready falls until out_ready returns or the output drains.
// ----------------------------------------------------------------------------
module rgb_color_temperature_and_lux
	import rgbct_pkg::*;
#(
	parameter int COEF_FRAC_BITS   = 14,
	parameter int CHROMA_FRAC_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [RAW_W-1:0] red,
	input  wire logic [RAW_W-1:0] green,
	input  wire logic [RAW_W-1:0] blue,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [RAW_W-1:0]      color_temp,
	output logic [RAW_W-1:0]      illuminance,
	output logic                  temp_invalid
);

	localparam int CF  = COEF_FRAC_BITS;
	localparam int HF  = CHROMA_FRAC_BITS;
	localparam int CW  = CF + 2;           // signed coefficient
	localparam int PW  = CW + RAW_W + 1;   // one product
	localparam int XW  = CF + 21;          // X, Y, Z
	localparam int SSW = XW + 2;           // X+Y+Z
	localparam int QW1 = XW + HF;          // chromaticity quotient
	localparam int NMW = QW1 + 2;          // McCamy numerator and divisor
	localparam int QW2 = HF + 3;           // magnitude of n
	localparam int NNW = HF + 5;           // signed n
	localparam int HW  = TW + NNW;         // Horner product

	localparam logic signed [NMW-1:0] K332 =
		NMW'((64'sd3320 * (64'sd1 <<< HF) + 64'sd5000) / 64'sd10000);
	localparam logic signed [NMW-1:0] K1858 =
		NMW'((64'sd1858 * (64'sd1 <<< HF) + 64'sd5000) / 64'sd10000);

	// Coefficient rounded to nearest at CF bits, halves away from zero.
	function automatic logic signed [CW-1:0] coef_fix(int v);
		longint mag;
		mag = (v < 0) ? -longint'(v) : longint'(v);
		mag = (mag * (64'sd1 <<< CF) + 64'sd50000) / 64'sd100000;
		return (v < 0) ? CW'(-mag) : CW'(mag);
	endfunction

	// Product divided by 2^HF toward zero, plus a polynomial constant.
	function automatic logic signed [TW-1:0] scale_add(logic signed [HW-1:0] p,
			logic signed [TW-1:0] k);
		logic signed [HW-1:0] b;
		b = p + (p[HW-1] ? HW'((64'sd1 <<< HF) - 64'sd1) : HW'(0));
		return TW'(b >>> HF) + k;
	endfunction

	logic en;

	// The pipeline advances whenever the output slot is free or being taken.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: the nine matrix products.
	logic signed [PW-1:0] prod_s1 [9];
	logic                 v_s1;
	logic [RAW_W-1:0]     raw [3];

	assign raw[0] = red;
	assign raw[1] = green;
	assign raw[2] = blue;

	for (genvar k = 0; k < 9; k++) begin : g_prod
		localparam logic signed [CW-1:0] CK = coef_fix(MAT_E5[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1[k] <= CK * $signed({1'b0, raw[k % 3]});
			end
		end
	end

	// Stage 2: the X, Y and Z rows.
	logic signed [XW-1:0] xyz_s2 [3];
	logic                 v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				xyz_s2[r] <= XW'(prod_s1[3*r]) + XW'(prod_s1[3*r+1]) + XW'(prod_s1[3*r+2]);
			end
		end
	end

	// Stage 3: the sum, magnitudes and signs for the chromaticity divides.
	logic signed [SSW-1:0] sum_c;
	logic [XW-1:0]         ax_s3, ay_s3;
	logic [SSW-1:0]        as_s3;
	logic                  nx_s3, ny_s3;
	tag_t                  tag_s3;
	logic                  v_s3;
	logic [RAW_W-1:0]      lux_c;

	assign sum_c = SSW'(xyz_s2[0]) + SSW'(xyz_s2[1]) + SSW'(xyz_s2[2]);

	// Illuminance is Y truncated; negatives clamp to zero, overflow to all ones.
	always_comb begin
		if (xyz_s2[1][XW-1]) begin
			lux_c = '0;
		end else if (|xyz_s2[1][XW-2:CF+RAW_W]) begin
			lux_c = '1;
		end else begin
			lux_c = xyz_s2[1][CF+RAW_W-1:CF];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s3      <= xyz_s2[0][XW-1] ? XW'(-xyz_s2[0]) : XW'(xyz_s2[0]);
			ay_s3      <= xyz_s2[1][XW-1] ? XW'(-xyz_s2[1]) : XW'(xyz_s2[1]);
			as_s3      <= sum_c[SSW-1] ? SSW'(-sum_c) : SSW'(sum_c);
			nx_s3      <= xyz_s2[0][XW-1] ^ sum_c[SSW-1];
			ny_s3      <= xyz_s2[1][XW-1] ^ sum_c[SSW-1];
			tag_s3.inv <= (sum_c == '0);
			tag_s3.lux <= lux_c;
		end
	end

	// Chromaticity dividers: x = X*2^HF / S and y = Y*2^HF / S.
	logic            vx_d, vy_d;
	logic [QW1-1:0]  qx_d, qy_d;
	logic            nx_d, ny_d;
	tag_t            tag_d;

	rgbct_div #(
		.NW(XW + HF), .DW(SSW), .QW(QW1), .SW($bits(tag_t) + 1)
	) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v_s3),
		.num({ax_s3, {HF{1'b0}}}), .den(as_s3), .side({nx_s3, tag_s3}),
		.out_vld(vx_d), .quo(qx_d), .side_out({nx_d, tag_d})
	);

	rgbct_div #(
		.NW(XW + HF), .DW(SSW), .QW(QW1), .SW(1)
	) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v_s3),
		.num({ay_s3, {HF{1'b0}}}), .den(as_s3), .side(ny_s3),
		.out_vld(vy_d), .quo(qy_d), .side_out(ny_d)
	);

	// Stage 4: McCamy numerator and divisor, clamp detection.
	logic signed [QW1:0]    xc_c, yc_c;
	logic signed [NMW-1:0]  num_c, den_c;
	logic [NMW-1:0]         un_c, ud_c;
	logic [NMW-1:0]         un_s4, ud_s4;
	logic                   negn_s4, clamp_s4;
	tag_t                   tag_s4;
	logic                   v_s4;

	assign xc_c  = nx_d ? -$signed({1'b0, qx_d}) : $signed({1'b0, qx_d});
	assign yc_c  = ny_d ? -$signed({1'b0, qy_d}) : $signed({1'b0, qy_d});
	assign num_c = NMW'(xc_c) - K332;
	assign den_c = K1858 - NMW'(yc_c);
	assign un_c  = num_c[NMW-1] ? NMW'(-num_c) : NMW'(num_c);
	assign ud_c  = den_c[NMW-1] ? NMW'(-den_c) : NMW'(den_c);

	always_ff @(posedge clk) begin
		if (en) begin
			un_s4      <= un_c;
			ud_s4      <= ud_c;
			negn_s4    <= num_c[NMW-1] ^ den_c[NMW-1];
			clamp_s4   <= (NMW+3)'(un_c) >= {ud_c, 3'b000};
			tag_s4.inv <= tag_d.inv || (den_c == '0);
			tag_s4.lux <= tag_d.lux;
		end
	end

	// Divider for |n| = |num|*2^HF / |den|, valid when |n| stays below 8.
	logic           vn_d;
	logic [QW2-1:0] qn_d;
	logic           negn_d, clamp_d;
	tag_t           tagn_d;

	rgbct_div #(
		.NW(NMW + HF), .DW(NMW), .QW(QW2), .SW($bits(tag_t) + 2)
	) u_div_n (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v_s4),
		.num({un_s4, {HF{1'b0}}}), .den(ud_s4),
		.side({negn_s4, clamp_s4, tag_s4}),
		.out_vld(vn_d), .quo(qn_d), .side_out({negn_d, clamp_d, tagn_d})
	);

	// Stage 5: signed n, clamped to plus or minus eight.
	logic [NNW-1:0]        nmag_c;
	logic signed [NNW-1:0] n_s5;
	tag_t                  tag_s5;
	logic                  v_s5;

	assign nmag_c = clamp_d ? (NNW'(1) << (HF + 3)) : NNW'(qn_d);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s5   <= negn_d ? -$signed(nmag_c) : $signed(nmag_c);
			tag_s5 <= tagn_d;
		end
	end

	// Stages 6 to 11: Horner's rule, a multiply then a scale and add.
	logic signed [HW-1:0] p1_s6, p2_s8, p3_s10;
	logic signed [TW-1:0] t1_s7, t2_s9, t3_s11;
	logic signed [NNW-1:0] n_s6, n_s7, n_s8, n_s9;
	tag_t tag_s6, tag_s7, tag_s8, tag_s9, tag_s10, tag_s11;
	logic v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s6   <= K449 * n_s5;
			n_s6    <= n_s5;
			tag_s6  <= tag_s5;
			t1_s7   <= scale_add(p1_s6, K3525);
			n_s7    <= n_s6;
			tag_s7  <= tag_s6;
			p2_s8   <= t1_s7 * n_s7;
			n_s8    <= n_s7;
			tag_s8  <= tag_s7;
			t2_s9   <= scale_add(p2_s8, K6823);
			n_s9    <= n_s8;
			tag_s9  <= tag_s8;
			p3_s10  <= t2_s9 * n_s9;
			tag_s10 <= tag_s9;
			t3_s11  <= scale_add(p3_s10, K5520);
			tag_s11 <= tag_s10;
		end
	end

	// Stage 12: saturate the temperature and drive the output register.
	logic [RAW_W-1:0] ct_c;
	logic [RAW_W-1:0] ct_s12, lux_s12;
	logic             inv_s12, v_s12;

	always_comb begin
		if (tag_s11.inv || t3_s11[TW-1]) begin
			ct_c = '0;
		end else if (|t3_s11[TW-2:POLY_FRAC_BITS+RAW_W]) begin
			ct_c = '1;
		end else begin
			ct_c = t3_s11[POLY_FRAC_BITS+RAW_W-1:POLY_FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ct_s12  <= ct_c;
			lux_s12 <= tag_s11.lux;
			inv_s12 <= tag_s11.inv;
		end
	end

	// Valid bits of the top-level stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= vx_d && vy_d;
			v_s5  <= vn_d;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	assign out_valid    = v_s12;
	assign color_temp   = ct_s12;
	assign illuminance  = lux_s12;
	assign temp_invalid = inv_s12;

endmodule
`default_nettype wire

### rtl/rgbct_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbct_div: pipelined unsigned restoring divider
// One quotient bit per stage, QW stages. The quotient must fit in QW bits.
// A sideband word and a valid bit travel with each operand pair.
// ----------------------------------------------------------------------------
module rgbct_div #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int QW = 16,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_vld,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side,
	output logic               out_vld,
	output logic [QW-1:0]      quo,
	output logic [SW-1:0]      side_out
);

	localparam int RW = DW + QW;

	logic [RW-1:0] rem_s  [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic [QW-1:0] quo_s  [QW+1];
	logic [SW-1:0] side_s [QW+1];
	logic          vld_s  [QW+1];

	// Stage zero is the operand input itself.
	assign rem_s[0]  = RW'(num);
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side;
	assign vld_s[0]  = in_vld;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int K = QW - 1 - i;
		logic [RW-1:0] dsh;
		logic          ge;

		// Try to subtract the divisor shifted to this quotient bit.
		assign dsh = RW'(den_s[i]) << K;
		assign ge  = rem_s[i] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? rem_s[i] - dsh : rem_s[i];
				quo_s[i+1]  <= quo_s[i] | (QW'(ge) << K);
				den_s[i+1]  <= den_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_vld  = vld_s[QW];
	assign quo      = quo_s[QW];
	assign side_out = side_s[QW];

endmodule
`default_nettype wire

### rtl/rgbct_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbct_chk: port-level checks of the color temperature block
// Watches both channels of the top level and is attached to it by bind.
// ----------------------------------------------------------------------------
module rgbct_chk
	import rgbct_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [RAW_W-1:0] color_temp,
	input wire logic [RAW_W-1:0] illuminance,
	input wire logic             temp_invalid
);

	// A stalled result transaction holds its valid and payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(color_temp)
			&& $stable(illuminance) && $stable(temp_invalid))
		else $error("stalled result changed");

	// An invalid chromaticity always reports zero temperature.
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && temp_invalid |-> color_temp == '0)
		else $error("invalid result with nonzero temperature");

	// Input is taken exactly when the output slot is free or being drained.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow the output slot");

	// While the pipeline holds, no input transaction is taken.
	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !(in_valid && in_ready))
		else $error("input taken during a stall");

endmodule

bind rgb_color_temperature_and_lux rgbct_chk u_rgbct_chk (.*);
`default_nettype wire
